// File: src/lcstbw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcstbw_pkg - shared types and constants for the lcs tile block
// Word formats, cell command and token types, opcodes and controller states.
// ----------------------------------------------------------------------------
package lcstbw_pkg;

    localparam int SYM_W    = 32;
    localparam int WEIGHT_W = 32;
    localparam int IDX_W    = 10;
    localparam int COUNT_W  = 11;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ROW  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        column_index;
        logic signed [SYM_W-1:0] symbol;
        logic [WEIGHT_W-1:0]     weight;
    } t_in_word;

    typedef struct packed {
        logic                result_kind;
        logic [WEIGHT_W-1:0] result_weight;
    } t_out_word;

    // left weight travelling from cell to cell
    typedef struct packed {
        logic                valid;
        logic [WEIGHT_W-1:0] left;
    } t_token;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                start;
        logic                last;
        logic                acc;
        logic                load;
        logic [IDX_W-1:0]    col;
        logic [SYM_W-1:0]    sym;
        logic [WEIGHT_W-1:0] weight;
    } t_cell_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RDWAIT,
        ST_GRAB,
        ST_FIN
    } t_state;

endpackage
`default_nettype wire

// File: src/lcstbw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcstbw_ram - generic single write port RAM with registered read
// One write and one read address per cycle, read data valid the next cycle.
// ----------------------------------------------------------------------------
module lcstbw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: src/lcstbw_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcstbw_cell - one cell of the column chain
// Holds every column whose index is CELL_ID modulo the cell count, updates
// the column weight when the left weight token passes and hands it on.
// ----------------------------------------------------------------------------
module lcstbw_cell #(
    parameter int CELL_ID   = 0,
    parameter int CELL_BITS = 3,
    parameter int DEPTH     = 128,
    parameter int AW        = 7
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire lcstbw_pkg::t_cell_cmd                 i_cmd,
    input  wire lcstbw_pkg::t_token                    i_tok,
    output lcstbw_pkg::t_token                         o_tok,
    output logic [lcstbw_pkg::WEIGHT_W-1:0]            o_rd_weight
);
    import lcstbw_pkg::*;

    localparam int RAM_W = SYM_W + WEIGHT_W;

    logic [AW-1:0]       r_pass;
    logic [AW-1:0]       n_pass;
    logic                r_valid;
    logic                n_valid;
    logic [WEIGHT_W-1:0] r_left;
    logic [WEIGHT_W-1:0] n_left;

    logic [31:0]         col_wide;
    logic [AW-1:0]       caddr;
    logic                sel;
    logic [RAM_W-1:0]    rd_data;
    logic [SYM_W-1:0]    rd_sym;
    logic [WEIGHT_W-1:0] rd_weight;
    logic                match;
    logic [WEIGHT_W-1:0] lo;
    logic [WEIGHT_W-1:0] hi;
    logic [WEIGHT_W-1:0] new_left;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [RAM_W-1:0]    wdata;
    logic [AW-1:0]       raddr;

    assign col_wide = 32'(i_cmd.col) >> CELL_BITS;
    assign caddr    = col_wide[AW-1:0];
    assign sel      = (i_cmd.col[CELL_BITS-1:0] == CELL_BITS'(CELL_ID));

    assign rd_sym    = rd_data[RAM_W-1:WEIGHT_W];
    assign rd_weight = rd_data[WEIGHT_W-1:0];

    // match takes the smaller weight plus one, saturating; else the larger
    always_comb begin
        match = (i_cmd.sym == rd_sym);
        lo    = (i_tok.left < rd_weight) ? i_tok.left : rd_weight;
        hi    = (i_tok.left > rd_weight) ? i_tok.left : rd_weight;
        if (match) begin
            new_left = (lo == WEIGHT_MAX) ? WEIGHT_MAX : lo + 1'b1;
        end else begin
            new_left = hi;
        end
    end

    always_comb begin
        if (i_tok.valid) begin
            we    = 1'b1;
            waddr = r_pass;
            wdata = {rd_sym, new_left};
        end else begin
            we    = i_cmd.load && sel;
            waddr = caddr;
            wdata = {i_cmd.sym, i_cmd.weight};
        end
        // prefetch the next pass while the token is here
        if (i_cmd.acc) begin
            raddr = caddr;
        end else if (i_cmd.start) begin
            raddr = '0;
        end else if (i_tok.valid) begin
            raddr = r_pass + 1'b1;
        end else begin
            raddr = r_pass;
        end
    end

    always_comb begin
        n_pass  = r_pass;
        n_valid = i_tok.valid && !i_cmd.last;
        n_left  = r_left;
        if (i_cmd.start) begin
            n_pass = '0;
        end else if (i_tok.valid) begin
            n_pass = r_pass + 1'b1;
        end
        if (i_tok.valid) begin
            n_left = new_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pass  <= '0;
        end else begin
            r_valid <= n_valid;
            r_pass  <= n_pass;
        end
        r_left <= n_left;
    end

    lcstbw_ram #(
        .WIDTH (RAM_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    assign o_tok       = '{valid: r_valid, left: r_left};
    assign o_rd_weight = rd_weight;

endmodule
`default_nettype wire

// File: src/lcs_tile_boundary_weights.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcs_tile_boundary_weights - lcs tile with boundary weights
// Column symbols and weights live in a chain of cells, column c in cell
// c mod 2**CELL_BITS. A left weight token walks the chain, one column a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (valid/ready) carry opcode, column index, symbol and weight.
//   A load writes one column and is done in its accept cycle; the block is
//   ready again on the next cycle and gives no result.
//   A row sweeps n columns (column_count clamped to 1..MAX_COLUMNS): after
//   acceptance the token passes through the cells, then the final weight goes
//   to a result register and on to the output register. A read does the cell
//   RAM read and collects the weight the same way. One item is worked on at a
//   time; o_in_ready is high only when idle. Results sit in an output
//   register. If the receiver stalls, the block finishes the current item and
//   waits to hand it over, then takes the next. Reset clears control state and
//   sets column_count to 1; column stores are undefined until loaded. i_cfg_we
//   writes column_count; the user must do so only while idle (not enforced).
// ----------------------------------------------------------------------------
module lcs_tile_boundary_weights #(
    parameter int MAX_COLUMNS = 1024,
    parameter int CELL_BITS   = 3
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire lcstbw_pkg::t_in_word              i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output lcstbw_pkg::t_out_word                  o_out_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [lcstbw_pkg::COUNT_W-1:0]    i_cfg_wdata
);
    import lcstbw_pkg::*;

    localparam int NUM_CELLS  = 1 << CELL_BITS;
    localparam int CELL_DEPTH = (MAX_COLUMNS + NUM_CELLS - 1) / NUM_CELLS;
    localparam int AW         = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int COL_W      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    t_state               r_state;
    t_state               n_state;
    logic [COUNT_W-1:0]   r_column_count;
    logic [SYM_W-1:0]     r_sym;
    logic [SYM_W-1:0]     n_sym;
    logic [WEIGHT_W-1:0]  r_w;
    logic [WEIGHT_W-1:0]  n_w;
    logic [COL_W-1:0]     r_last_col;
    logic [COL_W-1:0]     n_last_col;
    logic [COL_W-1:0]     r_col;
    logic [COL_W-1:0]     n_col;
    logic [CELL_BITS-1:0] r_cell;
    logic [CELL_BITS-1:0] n_cell;
    logic [CELL_BITS-1:0] r_fin_cell;
    logic [CELL_BITS-1:0] n_fin_cell;
    logic [CELL_BITS-1:0] r_rd_cell;
    logic [CELL_BITS-1:0] n_rd_cell;
    logic                 r_rd_ok;
    logic                 n_rd_ok;
    logic [WEIGHT_W-1:0]  r_res;
    logic [WEIGHT_W-1:0]  n_res;
    logic                 r_kind;
    logic                 n_kind;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_out_word            r_out_word;
    t_out_word            n_out_word;

    logic                 accept;
    logic                 in_range;
    logic                 sweep_last;
    logic                 inject;
    logic                 out_free;
    logic                 out_load;
    logic [31:0]          cc_wide;
    logic [31:0]          n_use;
    t_cell_cmd            cmd;

    t_token               tok_in  [NUM_CELLS];
    t_token               tok_out [NUM_CELLS];
    logic [WEIGHT_W-1:0]  rd_weight [NUM_CELLS];

    assign in_range   = (32'(i_in_word.column_index) < 32'(MAX_COLUMNS));
    assign sweep_last = (r_state == ST_SWEEP) && (r_col == r_last_col);
    assign out_free   = !r_out_valid || i_out_ready;

    // columns in use: zero counts as one, capped at the array size
    assign cc_wide = 32'(r_column_count);
    assign n_use   = (cc_wide == 32'd0) ? 32'd1 :
                     ((cc_wide > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS) : cc_wide);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in_word.opcode == OP_ROW) begin
                    n_state = ST_SWEEP;
                end else if (accept && i_in_word.opcode == OP_READ) begin
                    n_state = ST_RDWAIT;
                end
            end
            ST_SWEEP: begin
                if (sweep_last) begin
                    n_state = ST_GRAB;
                end
            end
            ST_RDWAIT: n_state = ST_FIN;
            ST_GRAB:   n_state = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and cell commands
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        accept     = i_in_valid && o_in_ready;
        inject     = (r_state == ST_SWEEP) && (r_col == '0);
        out_load   = (r_state == ST_FIN) && out_free;

        cmd.start  = accept && (i_in_word.opcode == OP_ROW);
        cmd.last   = sweep_last;
        cmd.acc    = accept && (i_in_word.opcode == OP_LOAD ||
                                i_in_word.opcode == OP_READ);
        cmd.load   = accept && (i_in_word.opcode == OP_LOAD) && in_range;
        cmd.col    = i_in_word.column_index;
        cmd.sym    = (r_state == ST_IDLE) ? i_in_word.symbol : r_sym;
        cmd.weight = i_in_word.weight;
    end

    // datapath next values
    always_comb begin
        n_sym      = r_sym;
        n_w        = r_w;
        n_last_col = r_last_col;
        n_col      = r_col;
        n_cell     = r_cell;
        n_fin_cell = r_fin_cell;
        n_rd_cell  = r_rd_cell;
        n_rd_ok    = r_rd_ok;
        n_res      = r_res;
        n_kind     = r_kind;

        if (accept) begin
            n_sym      = i_in_word.symbol;
            n_w        = i_in_word.weight;
            n_last_col = COL_W'(n_use - 32'd1);
            n_col      = '0;
            n_cell     = '0;
            n_rd_cell  = i_in_word.column_index[CELL_BITS-1:0];
            n_rd_ok    = in_range;
        end

        case (r_state)
            ST_SWEEP: begin
                n_col  = r_col + 1'b1;
                n_cell = r_cell + 1'b1;
                if (sweep_last) begin
                    n_fin_cell = r_cell;
                end
            end
            ST_RDWAIT: begin
                n_res  = r_rd_ok ? rd_weight[r_rd_cell] : '0;
                n_kind = KIND_READ;
            end
            ST_GRAB: begin
                n_res  = tok_out[r_fin_cell].left;
                n_kind = KIND_ROW;
            end
            default: ;
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_word  = '{result_kind: r_kind, result_weight: r_res};
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
            n_out_word  = r_out_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_column_count <= COUNT_W'(1);
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_column_count <= i_cfg_wdata;
            end
        end
        r_sym      <= n_sym;
        r_w        <= n_w;
        r_last_col <= n_last_col;
        r_col      <= n_col;
        r_cell     <= n_cell;
        r_fin_cell <= n_fin_cell;
        r_rd_cell  <= n_rd_cell;
        r_rd_ok    <= n_rd_ok;
        r_res      <= n_res;
        r_kind     <= n_kind;
        r_out_word <= n_out_word;
    end

    // cell 0 takes the incoming left weight first, then the wrapped token
    assign tok_in[0] = inject ? '{valid: 1'b1, left: r_w} : tok_out[NUM_CELLS-1];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign tok_in[k] = tok_out[k-1];
        end
        lcstbw_cell #(
            .CELL_ID   (k),
            .CELL_BITS (CELL_BITS),
            .DEPTH     (CELL_DEPTH),
            .AW        (AW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_tok       (tok_in[k]),
            .o_tok       (tok_out[k]),
            .o_rd_weight (rd_weight[k])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

// File: src/lcstbw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcstbw_checker - port level checks for the lcs tile block
// Watches the handshakes and the busy behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module lcstbw_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire lcstbw_pkg::t_in_word              i_in_word,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire lcstbw_pkg::t_out_word             o_out_word,
    input wire logic                              i_cfg_we,
    input wire logic [lcstbw_pkg::COUNT_W-1:0]    i_cfg_wdata
);
    import lcstbw_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // a row or a read keeps the block busy on the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_in_word.opcode == OP_ROW || i_in_word.opcode == OP_READ)
        |=> !o_in_ready)
        else $error("input taken while a row or read is in progress");

    // a load finishes in its accept cycle
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_word.opcode == OP_LOAD |=> o_in_ready)
        else $error("block busy after a load");

    // column count is written only while the block is idle and empty
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready && !o_out_valid && !$isunknown(i_cfg_wdata))
        else $error("column count written while busy");

endmodule

bind lcs_tile_boundary_weights lcstbw_checker u_lcstbw_checker (.*);
`default_nettype wire
